// ----- design/sdaf_pkg.sv -----
// Shared types and constants for the signed decimal ASCII formatter.
package sdaf_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitIdxW  = 4;
  localparam int unsigned BitCntW    = 5;

  localparam logic [6:0] CharMinus = 7'd45;
  localparam logic [6:0] CharZero  = 7'd48;
  localparam logic [3:0] MaxDigits = 4'd10;
  localparam logic [3:0] BcdAdjMin = 4'd5;
  localparam logic [3:0] BcdAdj    = 4'd3;

  // Input word
  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         min_digits;
  } cmd_t;

  // Output word
  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last_char;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit_sign;
    logic emit_digit;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic pos_zero;
  } dp_stat_t;

endpackage

// ----- design/sdaf_ctrl.sv -----
// Controller state machine: sequences load, conversion and character output.
module sdaf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  sdaf_pkg::dp_stat_t stat_i,
  output sdaf_pkg::dp_ctrl_t ctrl_o,
  output logic              busy
);

  sdaf_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdaf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      sdaf_pkg::ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = sdaf_pkg::ST_CONV;
        end
      end
      sdaf_pkg::ST_CONV: begin
        ctrl_o.shift = 1'b1;
        if (stat_i.conv_done) begin
          state_d = sdaf_pkg::ST_PREP;
        end
      end
      sdaf_pkg::ST_PREP: begin
        ctrl_o.prep = 1'b1;
        state_d     = stat_i.neg ? sdaf_pkg::ST_SIGN : sdaf_pkg::ST_DIGIT;
      end
      sdaf_pkg::ST_SIGN: begin
        ctrl_o.emit_sign = 1'b1;
        state_d          = sdaf_pkg::ST_DIGIT;
      end
      sdaf_pkg::ST_DIGIT: begin
        ctrl_o.emit_digit = 1'b1;
        if (stat_i.pos_zero) begin
          state_d = sdaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdaf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != sdaf_pkg::ST_IDLE);

endmodule

// ----- design/sdaf_dp.sv -----
// Datapath: magnitude, shift-add-3 BCD converter, digit pointer and output register.
module sdaf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdaf_pkg::cmd_t     cmd_i,
  input  sdaf_pkg::dp_ctrl_t ctrl_i,
  output sdaf_pkg::dp_stat_t stat_o,
  output sdaf_pkg::res_t     result_o,
  output logic               strobe_o
);

  logic [sdaf_pkg::ValueWidth-1:0]      mag_q, mag_d;
  logic [sdaf_pkg::NumDigits-1:0][3:0]  bcd_q, bcd_d, bcd_adj;
  logic [sdaf_pkg::BitCntW-1:0]         cnt_q, cnt_d;
  logic [sdaf_pkg::DigitIdxW-1:0]       pos_q, pos_d;
  logic [3:0]                           mind_q, mind_d;
  logic                                 neg_q, neg_d;
  logic                                 strobe_q, strobe_d;
  sdaf_pkg::res_t                       res_q, res_d;
  logic [3:0]                           ndig, width;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sdaf_pkg::NumDigits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= sdaf_pkg::BcdAdjMin) ? bcd_q[i] + sdaf_pkg::BcdAdj
                                                     : bcd_q[i];
    end
  end

  // Count of significant digits
  always_comb begin
    ndig = '0;
    for (int i = 0; i < sdaf_pkg::NumDigits; i++) begin
      if (bcd_q[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  // Field width: at least one digit, at least the clamped minimum
  always_comb begin
    width = (ndig > mind_q) ? ndig : mind_q;
    if (width == 4'd0) begin
      width = 4'd1;
    end
  end

  // Register updates
  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    mind_d   = mind_q;
    neg_d    = neg_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    if (ctrl_i.load) begin
      neg_d  = cmd_i.value[sdaf_pkg::ValueWidth-1];
      mag_d  = neg_d ? (32'd0 - 32'(cmd_i.value)) : 32'(cmd_i.value);
      bcd_d  = '0;
      cnt_d  = '0;
      mind_d = (cmd_i.min_digits > sdaf_pkg::MaxDigits) ? sdaf_pkg::MaxDigits
                                                        : cmd_i.min_digits;
    end
    if (ctrl_i.shift) begin
      // top bit of the top digit drops out; the next magnitude bit enters at the bottom
      bcd_d = {bcd_adj[sdaf_pkg::NumDigits-1][2:0], bcd_adj[sdaf_pkg::NumDigits-2:0],
               mag_q[sdaf_pkg::ValueWidth-1]};
      mag_d = {mag_q[sdaf_pkg::ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end
    if (ctrl_i.prep) begin
      pos_d = width - 4'd1;
    end
    if (ctrl_i.emit_sign) begin
      strobe_d        = 1'b1;
      res_d.ascii_char = sdaf_pkg::CharMinus;
      res_d.last_char  = 1'b0;
    end
    if (ctrl_i.emit_digit) begin
      strobe_d         = 1'b1;
      res_d.ascii_char = sdaf_pkg::CharZero + {3'd0, bcd_q[pos_q]};
      res_d.last_char  = (pos_q == '0);
      pos_d            = pos_q - 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    pos_q  <= pos_d;
    mind_q <= mind_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign stat_o.conv_done = (cnt_q == {sdaf_pkg::BitCntW{1'b1}});
  assign stat_o.neg       = neg_q;
  assign stat_o.pos_zero  = (pos_q == '0);
  assign result_o         = res_q;
  assign strobe_o         = strobe_q;

endmodule

// ----- design/signed_decimal_ascii_formatter.sv -----
// Top level of the signed decimal ASCII formatter.
// A word is taken when start is high and busy is low. The 32-bit value is
// converted to BCD by shift-add-3, one bit per cycle, then a prep state
// sets the field width, then one character leaves per cycle: an
// optional '-', then the digits, most significant first, zero padded to
// min_digits (clamped to 10), with last_char on the final one. Each
// character is shown on result_o for one cycle with strobe_o high and
// cannot be held off; the final character is shown while busy is already
// low, so the next word may be taken in that cycle.
module signed_decimal_ascii_formatter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  sdaf_pkg::cmd_t cmd_i,
  output logic           busy,
  output sdaf_pkg::res_t result_o,
  output logic           strobe_o
);

  sdaf_pkg::dp_ctrl_t ctrl;
  sdaf_pkg::dp_stat_t stat;

  sdaf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  sdaf_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .result_o (result_o),
    .strobe_o (strobe_o)
  );

endmodule

// ----- design/sdaf_checker.sv -----
// Port-level assertions for the formatter and their bind to the top level.
module sdaf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input sdaf_pkg::res_t result_o,
  input logic           strobe_o
);

  // An accepted word makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // Only '-' or a digit leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.ascii_char == sdaf_pkg::CharMinus) ||
                 ((result_o.ascii_char >= 7'd48) && (result_o.ascii_char <= 7'd57)))
    else $error("illegal character");

  // The sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (result_o.ascii_char == sdaf_pkg::CharMinus) |-> !result_o.last_char)
    else $error("sign flagged as last");

  // Characters of one number leave in consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.last_char |=> strobe_o)
    else $error("gap inside a number");

  // Going idle coincides with the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe_o && result_o.last_char)
    else $error("busy fell without final character");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .result_o (result_o),
  .strobe_o (strobe_o)
);
